[hdl/ibp_pkg.sv]
// Shared types and constants of the I/Q block power meter.
// No dependencies; every other file of the block imports this package.
package ibp_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned POWER_W      = 15;
  localparam int unsigned PAIR_COUNT_W = 18;
  localparam int unsigned ENERGY_W     = 17;
  localparam int unsigned FS_W         = 16;
  localparam int unsigned MANT_W       = 30;
  localparam int unsigned FULL_SCALE_SQ = 65025;
  localparam int          DB_SCALE     = 771;
  localparam int          THREE_DB     = 768;
  localparam int          PWR_MIN      = -12800;
  localparam int          PWR_MAX      = 256;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_LOAD,
    ST_NORM,
    ST_SQUARE,
    ST_UPDATE,
    ST_SAVE,
    ST_DIFF,
    ST_OUT
  } ibp_state_e;

  typedef struct packed {
    logic acc_en;
    logic ld_sum;
    logic den_load;
    logic ld_den;
    logic shift;
    logic mant_load;
    logic square;
    logic update;
    logic save_sum;
    logic diff;
    logic emit;
  } ibp_cmd_t;

  typedef struct packed {
    logic xs_msb;
    logic xs_zero;
    logic frac_last;
  } ibp_status_t;

endpackage

[hdl/ibp_if.sv]
// Stream interfaces of the block power meter: sample pairs in, results out.
// Depends on ibp_pkg for the field widths.
interface ibp_in_if;
  import ibp_pkg::*;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   i_byte;
  logic [BYTE_W-1:0]   q_byte;
  logic                block_end;
  modport source (output valid, i_byte, q_byte, block_end, input ready);
  modport sink   (input valid, i_byte, q_byte, block_end, output ready);
endinterface

interface ibp_out_if;
  import ibp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [POWER_W-1:0] power_dbfs;
  logic [PAIR_COUNT_W-1:0]   pair_count;
  logic                      count_overflow;
  modport source (output valid, power_dbfs, pair_count, count_overflow, input ready);
  modport sink   (input valid, power_dbfs, pair_count, count_overflow, output ready);
endinterface

[hdl/ibp_dp.sv]
// Datapath of the block power meter: energy accumulation, iterative log2 and dB scaling.
// Depends on ibp_pkg; driven by the commands of ibp_ctrl.
module ibp_dp #(
  parameter int unsigned MAX_SAMPLES   = 131072,
  parameter int unsigned LOG_FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ibp_pkg::ibp_cmd_t                   cmd_i,
  output ibp_pkg::ibp_status_t                status_o,
  input  logic [ibp_pkg::BYTE_W-1:0]          i_byte_i,
  input  logic [ibp_pkg::BYTE_W-1:0]          q_byte_i,
  output logic signed [ibp_pkg::POWER_W-1:0]  power_dbfs_o,
  output logic [ibp_pkg::PAIR_COUNT_W-1:0]    pair_count_o,
  output logic                                count_overflow_o
);
  import ibp_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW  = CW + ENERGY_W;
  localparam int unsigned DW  = CW + FS_W;
  localparam int unsigned LW  = (SW > MANT_W + 1) ? SW : MANT_W + 1;
  localparam int unsigned NW  = $clog2(LW);
  localparam int unsigned AW  = NW + LOG_FRAC_BITS;
  localparam int unsigned FCW = $clog2(LOG_FRAC_BITS + 1);
  localparam int unsigned PW  = AW + 12;
  localparam int unsigned MW  = MANT_W + 1;

  localparam logic signed [PW-1:0] PMIN = PW'(PWR_MIN);
  localparam logic signed [PW-1:0] PMAX = PW'(PWR_MAX);

  // Accumulation.
  logic signed [9:0]  ci, cq;
  logic signed [19:0] pi, pq;
  logic [ENERGY_W-1:0] e_d, e_q;
  logic                e_vld_q;
  logic [SW-1:0]       sum_q;
  logic [CW-1:0]       cnt_q;
  logic                ovf_q;
  logic                full;

  assign ci  = $signed({1'b0, i_byte_i, 1'b0}) - 10'sd255;
  assign cq  = $signed({1'b0, q_byte_i, 1'b0}) - 10'sd255;
  assign pi  = ci * ci;
  assign pq  = cq * cq;
  assign e_d = ENERGY_W'(pi[15:0]) + ENERGY_W'(pq[15:0]);
  assign full = (cnt_q == CW'(MAX_SAMPLES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      e_q <= e_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      sum_q   <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.emit) begin
      e_vld_q <= 1'b0;
      sum_q   <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      e_vld_q <= 1'b0;
      if (cmd_i.acc_en) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q   <= cnt_q + CW'(1);
          e_vld_q <= 1'b1;
        end
      end
      if (e_vld_q) begin
        sum_q <= sum_q + SW'(e_q);
      end
    end
  end

  // Denominator: count times full-scale power.
  logic [DW-1:0] den_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.den_load) begin
      den_q <= DW'(cnt_q) * DW'(FULL_SCALE_SQ);
    end
  end

  // Log2: normalize by single-bit shifts, then one squaring per fraction bit.
  logic [LW-1:0]    xs_q;
  logic [NW-1:0]    sh_q;
  logic [MW-1:0]    m_q;
  logic [2*MW-1:0]  prod_q;
  logic [AW-1:0]    acc_q, lsum_q;
  logic [FCW-1:0]   fcnt_q;
  logic [MW:0]      sq;
  logic             fbit;

  assign sq   = prod_q[2*MW-1:MANT_W];
  assign fbit = sq[MW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_sum) begin
      xs_q <= LW'(sum_q);
      sh_q <= '0;
    end else if (cmd_i.ld_den) begin
      xs_q <= LW'(den_q);
      sh_q <= '0;
    end else if (cmd_i.shift) begin
      xs_q <= {xs_q[LW-2:0], 1'b0};
      sh_q <= sh_q + NW'(1);
    end
    if (cmd_i.mant_load) begin
      m_q    <= xs_q[LW-1 -: MW];
      acc_q  <= status_o.xs_zero ? '0 : (AW'(LW - 1) - AW'(sh_q));
      fcnt_q <= '0;
    end else if (cmd_i.update) begin
      m_q    <= fbit ? sq[MW:1] : sq[MW-1:0];
      acc_q  <= {acc_q[AW-2:0], fbit};
      fcnt_q <= fcnt_q + FCW'(1);
    end
    if (cmd_i.square) begin
      prod_q <= m_q * m_q;
    end
    if (cmd_i.save_sum) begin
      lsum_q <= acc_q;
    end
  end

  assign status_o.xs_msb    = xs_q[LW-1];
  assign status_o.xs_zero   = (xs_q == '0);
  assign status_o.frac_last = (fcnt_q == FCW'(LOG_FRAC_BITS - 1));

  // Scaling to dB: difference times 771, floor shift, minus 3 dB, clamp.
  logic signed [AW:0]   dsig;
  logic signed [PW-1:0] dext, scaled_q, shifted, pre, clamped;

  assign dsig = $signed({1'b0, lsum_q}) - $signed({1'b0, acc_q});
  assign dext = PW'(dsig);

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      scaled_q <= dext * PW'(DB_SCALE);
    end
  end

  always_comb begin
    shifted = scaled_q >>> LOG_FRAC_BITS;
    pre     = shifted - PW'(THREE_DB);
    priority if (pre < PMIN) begin
      clamped = PMIN;
    end else if (pre > PMAX) begin
      clamped = PMAX;
    end else begin
      clamped = pre;
    end
  end

  assign power_dbfs_o     = clamped[POWER_W-1:0];
  assign pair_count_o     = PAIR_COUNT_W'(cnt_q);
  assign count_overflow_o = ovf_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_SAMPLES))
    else $error("pair count above its maximum");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (cnt_q == '0 && sum_q == '0 && !ovf_q))
    else $error("block state not cleared after a result");

  a_full_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.acc_en && !cmd_i.emit && full) |=> (ovf_q && $stable(cnt_q)))
    else $error("pair taken at full count not flagged as dropped");

  a_norm_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mant_load |-> (status_o.xs_msb || status_o.xs_zero))
    else $error("mantissa taken before normalization finished");

endmodule

[hdl/ibp_ctrl.sv]
// Sequencer of the block power meter: accumulation, two log2 passes and result hand-off.
// Depends on ibp_pkg; issues commands to ibp_dp.
module ibp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_block_end_i,
  input  logic                  out_free_i,
  input  ibp_pkg::ibp_status_t  status_i,
  output logic                  in_ready_o,
  output ibp_pkg::ibp_cmd_t     cmd_o
);
  import ibp_pkg::*;

  ibp_state_e state_q, state_d;
  logic       den_pass_q, den_pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_ACCUM;
      den_pass_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      den_pass_q <= den_pass_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    den_pass_d = den_pass_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_ACCUM: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc_en = 1'b1;
          if (in_block_end_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      // The last pair's energy is still in the pipeline register.
      ST_DRAIN: state_d = ST_LOAD;
      ST_LOAD: begin
        cmd_o.ld_sum   = 1'b1;
        cmd_o.den_load = 1'b1;
        den_pass_d     = 1'b0;
        state_d        = ST_NORM;
      end
      ST_NORM: begin
        if (status_i.xs_msb || status_i.xs_zero) begin
          cmd_o.mant_load = 1'b1;
          state_d         = ST_SQUARE;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        if (!status_i.frac_last) begin
          state_d = ST_SQUARE;
        end else if (den_pass_q) begin
          state_d = ST_DIFF;
        end else begin
          state_d = ST_SAVE;
        end
      end
      ST_SAVE: begin
        cmd_o.save_sum = 1'b1;
        cmd_o.ld_den   = 1'b1;
        den_pass_d     = 1'b1;
        state_d        = ST_NORM;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          den_pass_d = 1'b0;
          state_d    = ST_ACCUM;
        end
      end
      default: state_d = ST_ACCUM;
    endcase
  end

endmodule

[hdl/iq_block_power_dbfs_unit.sv]
// Top level of the I/Q block power meter: sequencer, datapath and result register.
// Depends on ibp_pkg, ibp_if, ibp_dp and ibp_ctrl.
//
// The meter takes one 8-bit offset-binary I/Q pair per beat, centers each
// component as 2x-255, and sums the squared magnitude with a pair count. Pairs
// are accepted one per cycle for as long as the block lasts. The beat that
// carries block_end closes the block: input ready then drops while the meter
// forms log2 of the energy sum and of count*65025, each by a leading-one search
// that shifts one bit per cycle followed by one truncated squaring per fraction
// bit, and converts the difference to dBFS in 1/256 dB steps (times 771/256,
// minus 3 dB, clamped to -12800..256). Both log passes run in turn on the
// shared log2 shifter and squarer, whose width LW is the larger of 31 and
// clog2(MAX_SAMPLES+1)+17. The result sits in an output register, so the next
// block's pairs are accepted while it waits to be taken; only a second result
// waiting behind it holds the meter.
// A block longer than MAX_SAMPLES pairs keeps its first MAX_SAMPLES, reports a
// saturated count and sets count_overflow; all block state clears as the
// result is issued.
module iq_block_power_dbfs_unit #(
  parameter int unsigned MAX_SAMPLES   = 131072,
  parameter int unsigned LOG_FRAC_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ibp_in_if.sink     in_i,
  ibp_out_if.source  out_o
);
  import ibp_pkg::*;

  ibp_cmd_t    cmd;
  ibp_status_t status;
  logic        out_valid_q;
  logic        out_free;

  logic signed [POWER_W-1:0] dp_power;
  logic [PAIR_COUNT_W-1:0]   dp_count;
  logic                      dp_ovf;

  logic signed [POWER_W-1:0] power_q;
  logic [PAIR_COUNT_W-1:0]   count_q;
  logic                      ovf_q;

  // The output register is free when empty or when its beat is taken now.
  assign out_free = !out_valid_q || out_o.ready;

  ibp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_block_end_i (in_i.block_end),
    .out_free_i     (out_free),
    .status_i       (status),
    .in_ready_o     (in_i.ready),
    .cmd_o          (cmd)
  );

  ibp_dp #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .i_byte_i         (in_i.i_byte),
    .q_byte_i         (in_i.q_byte),
    .power_dbfs_o     (dp_power),
    .pair_count_o     (dp_count),
    .count_overflow_o (dp_ovf)
  );

  // Result register: loaded as the sequencer issues a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      power_q <= dp_power;
      count_q <= dp_count;
      ovf_q   <= dp_ovf;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.power_dbfs     = power_q;
  assign out_o.pair_count     = count_q;
  assign out_o.count_overflow = ovf_q;

endmodule

[tb/ibp_power_checker.sv]
// Scoreboard of the I/Q block power meter: watches the pair and result channels,
// predicts each block's dBFS result and compares it field by field.
// Depends on ibp_pkg and on the ibp_in_if and ibp_out_if interfaces.
`timescale 1ns / 100ps

module ibp_power_checker #(
  parameter int unsigned MAX_SAMPLES   = 131072,
  parameter int unsigned LOG_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ibp_in_if           pair_mon,
  ibp_out_if          res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import ibp_pkg::*;

  localparam int unsigned CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W    = CNT_W + 17;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [POWER_W-1:0] power_dbfs;
    logic [PAIR_COUNT_W-1:0]   pair_count;
    logic                      count_overflow;
  } block_result_t;

  block_result_t       result_q[$];
  logic [SUM_W-1:0]    energy_acc;
  logic [CNT_W-1:0]    pairs_acc;
  logic                dropped_seen;

  assign pending_o = result_q.size();

  // Log2 in units of 2^-LOG_FRAC_BITS: leading-one position plus fraction bits
  // taken from truncated squaring of a Q1.30 mantissa.
  function automatic longint log2_units(input logic [63:0] x);
    int          n;
    logic [63:0] m;
    longint      acc;
    if (x == 64'd0) return 0;
    n = 63;
    while (x[n] == 1'b0) n--;
    if (n >= MANT_W) m = x >> (n - MANT_W);
    else             m = x << (MANT_W - n);
    acc = n;
    for (int k = 0; k < LOG_FRAC_BITS; k++) begin
      m   = (m * m) >> MANT_W;
      acc = acc * 2;
      if (m >= (64'd2 << MANT_W)) begin
        acc = acc + 1;
        m   = m >> 1;
      end
    end
    return acc;
  endfunction

  function automatic block_result_t block_power(input logic [SUM_W-1:0] sum,
                                                input logic [CNT_W-1:0] count,
                                                input logic ovf);
    block_result_t r;
    logic [63:0]   full_scale;
    longint        diff;
    longint        pwr;
    full_scale = 64'(count) * 64'(FULL_SCALE_SQ);
    diff = log2_units(64'(sum)) - log2_units(full_scale);
    // Arithmetic shift of a signed value rounds toward minus infinity.
    pwr = ((diff * DB_SCALE) >>> LOG_FRAC_BITS) - THREE_DB;
    if (pwr < PWR_MIN) pwr = PWR_MIN;
    if (pwr > PWR_MAX) pwr = PWR_MAX;
    r.power_dbfs     = pwr[POWER_W-1:0];
    r.pair_count     = PAIR_COUNT_W'(count);
    r.count_overflow = ovf;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_acc   = '0;
      pairs_acc    = '0;
      dropped_seen = 1'b0;
      fail_count_o <= 0;
    end else begin : watch
      int            ci;
      int            cq;
      block_result_t want;
      block_result_t got;
      if (pair_mon.valid && pair_mon.ready) begin
        ci = 2 * int'(pair_mon.i_byte) - 255;
        cq = 2 * int'(pair_mon.q_byte) - 255;
        if (pairs_acc == CNT_W'(MAX_SAMPLES)) begin
          dropped_seen = 1'b1;
        end else begin
          energy_acc = energy_acc + SUM_W'(ci * ci + cq * cq);
          pairs_acc  = pairs_acc + 1'b1;
        end
        if (pair_mon.block_end) begin
          result_q = {result_q, block_power(energy_acc, pairs_acc, dropped_seen)};
          energy_acc   = '0;
          pairs_acc    = '0;
          dropped_seen = 1'b0;
        end
      end
      if (res_mon.valid && res_mon.ready) begin
        got.power_dbfs     = res_mon.power_dbfs;
        got.pair_count     = res_mon.pair_count;
        got.count_overflow = res_mon.count_overflow;
        if (result_q.size() == 0) begin
          if (fail_count_o < REPORT_LIMIT)
            $display("unexpected result beat: power %0d count %0d overflow %0b",
                     got.power_dbfs, got.pair_count, got.count_overflow);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            if (fail_count_o < REPORT_LIMIT)
              $display("result mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                       want.power_dbfs, want.pair_count, want.count_overflow,
                       got.power_dbfs, got.pair_count, got.count_overflow);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

[tb/iq_block_power_dbfs_unit_tb.sv]
// Top of the I/Q block power meter testbench: clock, reset, pair stimulus and
// result-side flow control. Depends on ibp_pkg, ibp_if, the meter and ibp_power_checker.
`timescale 1ns / 100ps

module iq_block_power_dbfs_unit_tb;
  import ibp_pkg::*;

  localparam int unsigned MAX_SAMPLES   = 131072;
  localparam int unsigned LOG_FRAC_BITS = 8;
  // Worst closing phase of one block.
  localparam int unsigned CLOSE_CYCLES  = 106;
  localparam int unsigned TAIL_CYCLES   = 3 * CLOSE_CYCLES;
  localparam int unsigned HOLD_CYCLES   = 600;

  typedef enum int unsigned {
    MIX_UNIFORM,
    MIX_EXTREME,
    MIX_QUIET,
    MIX_EDGES
  } sample_mix_e;

  logic        clk_i;
  logic        rst_ni;
  // Calm turns off random idling on both sides.
  logic        calm = 1'b0;
  // The stimulus asks for one long receiver hold-off; the receiver times it.
  logic        hold_req = 1'b0;
  logic        hold_done;
  int unsigned hold_left;
  int unsigned fail_count;
  int unsigned pending_results;

  ibp_in_if  pair_ch ();
  ibp_out_if res_ch ();

  iq_block_power_dbfs_unit #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .LOG_FRAC_BITS(LOG_FRAC_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pair_ch.sink),
    .out_o (res_ch.source)
  );

  ibp_power_checker #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .LOG_FRAC_BITS(LOG_FRAC_BITS)
  ) scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pair_mon    (pair_ch),
    .res_mon     (res_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending_results)
  );

  // 20 ns clock period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Result side. Ready drops on about a quarter of the cycles unless calm is
  // set. When the stimulus raises hold_req the first time, ready is held low
  // through one long hold-off timed by hold_left, so finished results pile up
  // inside the meter and it has to stall the pair input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      res_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      res_ch.ready <= calm || ($urandom_range(99) >= 24);
    end
  end

  // A generous bound on the run of about 400 pairs, far beyond what a correct
  // run needs.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] pick_byte(input sample_mix_e mix);
    logic [BYTE_W-1:0] b;
    case (mix)
      MIX_EXTREME: b = $urandom_range(1) ? 8'hFF : 8'h00;
      MIX_QUIET:   b = BYTE_W'($urandom_range(131, 124));
      MIX_EDGES: begin
        case ($urandom_range(5))
          0:       b = 8'h00;
          1:       b = 8'h01;
          2:       b = 8'h7F;
          3:       b = 8'h80;
          4:       b = 8'hFE;
          default: b = 8'hFF;
        endcase
      end
      default:     b = BYTE_W'($urandom_range(255));
    endcase
    return b;
  endfunction

  // Offers one pair and returns at the edge where it was taken. The random
  // idle cycles come before the beat, so valid is never dropped and raised in
  // the same step and stays up through a stall of the meter.
  task automatic send_beat(input logic [BYTE_W-1:0] i_b, input logic [BYTE_W-1:0] q_b,
                           input logic last);
    while (!calm && $urandom_range(99) < 24) begin
      pair_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pair_ch.valid     <= 1'b1;
    pair_ch.i_byte    <= i_b;
    pair_ch.q_byte    <= q_b;
    pair_ch.block_end <= last;
    @(posedge clk_i);
    while (!pair_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_block(input int unsigned len, input sample_mix_e mix);
    for (int unsigned k = 0; k < len; k++)
      send_beat(pick_byte(mix), pick_byte(mix), k == len - 1);
  endtask

  // Stops offering pairs until every expected result has been taken. The
  // first edge lets the checker record the block that was just closed.
  task automatic wait_drained();
    pair_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  // Random blocks, mostly short with now and then a longer one, until about
  // pair_budget pairs have gone out.
  task automatic send_random_blocks(input int unsigned pair_budget);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < pair_budget) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
      send_block(len, sample_mix_e'($urandom_range(3)));
      sent += len;
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    pair_ch.valid     <= 1'b0;
    pair_ch.i_byte    <= '0;
    pair_ch.q_byte    <= '0;
    pair_ch.block_end <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-pair blocks at both corners of full scale give the largest
    // power; a pair one step off center on both axes gives the smallest.
    send_beat(8'h00, 8'h00, 1'b1);
    send_beat(8'hFF, 8'hFF, 1'b1);
    send_beat(8'h7F, 8'h80, 1'b1);
    send_beat(8'h80, 8'h7F, 1'b1);
    // Full scale pairs in one block, then near-center and full scale pairs mixed in the next.
    send_beat(8'h00, 8'hFF, 1'b0);
    send_beat(8'hFF, 8'h00, 1'b1);
    send_beat(8'h7F, 8'h7F, 1'b0);
    send_beat(8'h80, 8'h80, 1'b0);
    send_beat(8'h00, 8'h7F, 1'b1);
    // Alternating bit patterns on both components, then full-scale and near-edge pairs.
    send_beat(8'h55, 8'hAA, 1'b0);
    send_beat(8'hAA, 8'h55, 1'b0);
    send_beat(8'hFF, 8'h00, 1'b0);
    send_beat(8'h01, 8'hFE, 1'b1);
    send_block(8, MIX_QUIET);

    send_random_blocks(120);

    // Long receiver hold-off while short blocks keep coming: the result
    // register fills, a second result waits behind it and the pair input
    // stalls until the hold ends.
    hold_req <= 1'b1;
    repeat (14) send_block($urandom_range(3, 1), sample_mix_e'($urandom_range(3)));
    wait_drained();

    // A stretch with no idling on either side.
    calm <= 1'b1;
    send_random_blocks(80);
    calm <= 1'b0;
    send_random_blocks(120);
    wait_drained();

    send_random_blocks(30);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
